FILE: hdl/assert_macros.svh
// Assertion macros shared by the console engine RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge, reset included.
`define TCC_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Check outside reset only.
`define TCC_ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

`endif

FILE: hdl/tcc_pkg.sv
// Types and constants of the text console engine.
// No dependencies; used by tcc_ctrl, tcc_dp and the top module.
package tcc_pkg;

  localparam int ROW_OUT_W = 5;
  localparam int COL_OUT_W = 7;
  localparam int POS_OUT_W = 11;
  localparam int CELL_W    = 16;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [7:0] CH_NL      = 8'd10;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_BS      = 8'd8;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] RESET_ATTR = 8'h07;

  // register index as seen in address bit 2
  localparam logic REG_COLOR_ATTR = 1'b0;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  char_code;
    logic [10:0] read_pos;
  } tcc_in_t;

  typedef struct packed {
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [COL_OUT_W-1:0] cursor_col;
    logic [POS_OUT_W-1:0] cursor_pos;
    logic [CELL_W-1:0]    read_cell;
    logic                 scrolled;
  } tcc_out_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_DRAIN,
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_DONE
  } tcc_state_e;

  typedef enum logic [1:0] {
    SW_INIT,
    SW_FILL,
    SW_SCROLL
  } tcc_sweep_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic sweep;
    logic rd_capture;
    logic emit;
  } tcc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start_sweep;
    logic is_read;
    logic sweep_last;
    logic init_mode;
  } tcc_stat_t;

endpackage

FILE: hdl/tcc_chan_if.sv
// Valid/ready channel carrying one payload struct per transaction.
// Payload type is set per instance, normally from tcc_pkg.
interface tcc_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/tcc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/tcc_ctrl.sv
// Sequencing state machine of the console engine.
// Depends on tcc_pkg and assert_macros.svh; drives the datapath commands.
`include "assert_macros.svh"

module tcc_ctrl
  import tcc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_ready_o,
  output logic      rsp_valid_o,
  input  logic      rsp_ready_i,
  input  tcc_stat_t stat_i,
  output tcc_cmd_t  ctl_o
);

  tcc_state_e state_q, state_d;
  logic       rsp_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ctl_o       = '0;
    cmd_ready_o = 1'b0;
    case (state_q)
      ST_SWEEP: begin
        ctl_o.sweep = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last sweep write lands here
        state_d = stat_i.init_mode ? ST_IDLE : ST_DONE;
      end
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctl_o.exec = 1'b1;
        if (stat_i.start_sweep) begin
          state_d = ST_SWEEP;
        end else if (stat_i.is_read) begin
          state_d = ST_RDWAIT;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_RDWAIT: begin
        ctl_o.rd_capture = 1'b1;
        state_d          = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!rsp_valid_q || rsp_ready_i) begin
          ctl_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (ctl_o.emit) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

  `TCC_ASSERT_RST(a_emit_slot_free, clk_i, rst_ni,
    ctl_o.emit |-> (!rsp_valid_q || rsp_ready_i), "result overwrites a pending one")
  `TCC_ASSERT_RST(a_read_waits, clk_i, rst_ni,
    (state_q == ST_EXEC && stat_i.is_read && !stat_i.start_sweep) |=> ctl_o.rd_capture,
    "read data not captured after issue")

endmodule

FILE: hdl/tcc_dp.sv
// Datapath of the console engine: cursor registers, sweep counter, screen RAM.
// Depends on tcc_pkg, tcc_ram and assert_macros.svh.
`include "assert_macros.svh"

module tcc_dp
  import tcc_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tcc_cmd_t   ctl_i,
  output tcc_stat_t  stat_o,
  input  tcc_in_t    in_i,
  input  logic [7:0] color_attr_i,
  output tcc_out_t   out_o
);

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int SWW   = $clog2(CELLS + COLS);
  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(ROWS);

  localparam logic [CW-1:0]  COL_LAST       = CW'(COLS - 1);
  localparam logic [RW-1:0]  ROW_LAST       = RW'(ROWS - 1);
  localparam logic [AW-1:0]  POS_COLS       = AW'(COLS);
  localparam logic [SWW-1:0] SW_COLS        = SWW'(COLS);
  localparam logic [SWW-1:0] SW_CELLS       = SWW'(CELLS);
  localparam logic [SWW-1:0] SW_FILL_LAST   = SWW'(CELLS - 1);
  localparam logic [SWW-1:0] SW_SCROLL_LAST = SWW'(CELLS + COLS - 1);

  // cursor and sweep control
  logic [RW-1:0]  row_q, row_d;
  logic [CW-1:0]  col_q, col_d;
  logic [AW-1:0]  pos_q, pos_d;
  tcc_sweep_e     mode_q;
  logic [SWW-1:0] sw_q;
  logic           wr_v_q;

  // latched command and result payload
  logic [1:0]     func_q;
  logic [7:0]     ch_q;
  logic [10:0]    rpos_q;
  logic [AW-1:0]  wr_a_q;
  logic           wr_blank_q;
  logic           scrolled_q;
  logic           rd_ok_q;
  logic [CELL_W-1:0] cell_q;
  tcc_out_t       out_q;

  logic              ex_we, scroll, clear, rd_ok;
  logic [AW-1:0]     ex_addr, raddr;
  logic [CELL_W-1:0] ex_data, rdata, wdata;
  logic [AW-1:0]     waddr;
  logic              we;
  logic [SWW-1:0]    wr_a_d;
  logic [7:0]        blank_attr;
  logic [31:0]       rpos_ext, row_ext, col_ext, pos_ext;

  // command decode against the current cursor
  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    pos_d   = pos_q;
    ex_we   = 1'b0;
    ex_addr = pos_q;
    ex_data = {color_attr_i, ch_q};
    scroll  = 1'b0;
    clear   = 1'b0;
    case (func_q)
      FUNC_PUT: begin
        case (ch_q)
          CH_NL: begin
            col_d = '0;
            if (row_q == ROW_LAST) begin
              scroll = 1'b1;
              pos_d  = pos_q - AW'(col_q);
            end else begin
              row_d = row_q + 1'b1;
              pos_d = pos_q - AW'(col_q) + POS_COLS;
            end
          end
          CH_CR: begin
            col_d = '0;
            pos_d = pos_q - AW'(col_q);
          end
          CH_BS: begin
            ex_addr = pos_q - 1'b1;
            ex_data = {color_attr_i, CH_SPACE};
            if (col_q != '0) begin
              col_d = col_q - 1'b1;
              pos_d = pos_q - 1'b1;
              ex_we = 1'b1;
            end else if (row_q != '0) begin
              row_d = row_q - 1'b1;
              col_d = COL_LAST;
              pos_d = pos_q - 1'b1;
              ex_we = 1'b1;
            end
          end
          default: begin
            ex_we = 1'b1;
            if (col_q == COL_LAST) begin
              col_d = '0;
              if (row_q == ROW_LAST) begin
                scroll = 1'b1;
                pos_d  = pos_q + 1'b1 - POS_COLS;
              end else begin
                row_d = row_q + 1'b1;
                pos_d = pos_q + 1'b1;
              end
            end else begin
              col_d = col_q + 1'b1;
              pos_d = pos_q + 1'b1;
            end
          end
        endcase
      end
      FUNC_CLEAR: begin
        clear = 1'b1;
        row_d = '0;
        col_d = '0;
        pos_d = '0;
      end
      default: ;
    endcase
  end

  assign rpos_ext = 32'(rpos_q);
  assign rd_ok    = rpos_ext < 32'(CELLS);

  assign stat_o.start_sweep = scroll | clear;
  assign stat_o.is_read     = (func_q == FUNC_READ);
  assign stat_o.sweep_last  = (sw_q == ((mode_q == SW_SCROLL) ? SW_SCROLL_LAST : SW_FILL_LAST));
  assign stat_o.init_mode   = (mode_q == SW_INIT);

  // scroll reads one row ahead of where it writes
  assign wr_a_d = (mode_q == SW_SCROLL) ? (sw_q - SW_COLS) : sw_q;

  always_comb begin
    if (ctl_i.exec) begin
      raddr = rd_ok ? rpos_ext[AW-1:0] : '0;
    end else begin
      raddr = (sw_q < SW_CELLS) ? sw_q[AW-1:0] : '0;
    end
  end

  assign blank_attr = (mode_q == SW_INIT) ? RESET_ATTR : color_attr_i;
  assign we    = wr_v_q | (ctl_i.exec & ex_we);
  assign waddr = wr_v_q ? wr_a_q : ex_addr;
  assign wdata = wr_v_q ? (wr_blank_q ? {blank_attr, CH_SPACE} : rdata) : ex_data;

  tcc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      pos_q  <= '0;
      mode_q <= SW_INIT;
      sw_q   <= '0;
      wr_v_q <= 1'b0;
    end else begin
      wr_v_q <= ctl_i.sweep;
      if (ctl_i.exec) begin
        row_q <= row_d;
        col_q <= col_d;
        pos_q <= pos_d;
        if (clear) begin
          mode_q <= SW_FILL;
          sw_q   <= '0;
        end else if (scroll) begin
          mode_q <= SW_SCROLL;
          sw_q   <= SW_COLS;
        end
      end else if (ctl_i.sweep) begin
        sw_q <= sw_q + 1'b1;
      end
    end
  end

  assign row_ext = 32'(row_q);
  assign col_ext = 32'(col_q);
  assign pos_ext = 32'(pos_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      func_q <= in_i.func;
      ch_q   <= in_i.char_code;
      rpos_q <= in_i.read_pos;
    end
    if (ctl_i.sweep) begin
      wr_a_q     <= wr_a_d[AW-1:0];
      wr_blank_q <= (mode_q != SW_SCROLL) || (sw_q >= SW_CELLS);
    end
    if (ctl_i.exec) begin
      scrolled_q <= scroll;
      rd_ok_q    <= rd_ok;
      cell_q     <= '0;
    end else if (ctl_i.rd_capture && rd_ok_q) begin
      cell_q <= rdata;
    end
    if (ctl_i.emit) begin
      out_q.cursor_row <= row_ext[ROW_OUT_W-1:0];
      out_q.cursor_col <= col_ext[COL_OUT_W-1:0];
      out_q.cursor_pos <= pos_ext[POS_OUT_W-1:0];
      out_q.read_cell  <= cell_q;
      out_q.scrolled   <= scrolled_q;
    end
  end

  assign out_o = out_q;

  `TCC_ASSERT_RST(a_one_writer, clk_i, rst_ni,
    !(wr_v_q && ctl_i.exec && ex_we), "sweep and command write collide")
  `TCC_ASSERT_RST(a_cursor_range, clk_i, rst_ni,
    (row_q <= ROW_LAST) && (col_q <= COL_LAST), "cursor outside the screen")
  `TCC_ASSERT_RST(a_pos_track, clk_i, rst_ni,
    pos_ext == (row_ext * 32'(COLS) + col_ext), "linear position out of step")
  `TCC_ASSERT(a_reset_pass, clk_i,
    !rst_ni |-> ((mode_q == SW_INIT) && (sw_q == '0) && !wr_v_q),
    "clearing pass not armed in reset")

endmodule

FILE: hdl/text_console_cursor_scroll_core.sv
// Text console engine: command and result channels, attribute register.
// Depends on tcc_pkg, tcc_chan_if, tcc_ctrl and tcc_dp.
//
// Usage:
//   cmd_i carries one command per transaction (put character, clear, read
//   one cell); rsp_o returns exactly one result per command with the cursor
//   after it, the cell read and a scroll flag. The APB port holds the
//   attribute byte used for written and blanked cells (reset 0x07); write
//   it only while no command is in flight.
// Timing:
//   Commands are handled one at a time. A put, carriage return, newline or
//   backspace gives its result after its execute step, a read after a
//   further step that captures the registered RAM data. A clear, or a put or
//   newline that scrolls, sweeps the screen RAM one cell a cycle through its single write port.
// Reset:
//   After reset a clearing pass writes blank cells with attribute 0x07,
//   during which cmd_i is not ready; APB writes are taken throughout.
// Stall:
//   A result is held in an output register until taken. The next command is
//   accepted meanwhile; its own result waits until the register is free.
module text_console_cursor_scroll_core
  import tcc_pkg::*;
#(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  tcc_chan_if.sink          cmd_i,
  tcc_chan_if.source        rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [7:0] color_attr_q;
  tcc_cmd_t   ctl;
  tcc_stat_t  stat;
  tcc_in_t    cmd_payload;
  tcc_out_t   rsp_payload;
  logic       cmd_ready;
  logic       rsp_valid;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_attr_q <= RESET_ATTR;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_COLOR_ATTR)) begin
      color_attr_q <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_COLOR_ATTR) ? {{(APB_DW - 8){1'b0}}, color_attr_q} : '0;

  assign cmd_payload   = cmd_i.payload;
  assign cmd_i.ready   = cmd_ready;
  assign rsp_o.valid   = rsp_valid;
  assign rsp_o.payload = rsp_payload;

  tcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_ready),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  tcc_dp #(
    .COLS (SCREEN_COLS),
    .ROWS (SCREEN_ROWS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .stat_o       (stat),
    .in_i         (cmd_payload),
    .color_attr_i (color_attr_q),
    .out_o        (rsp_payload)
  );

endmodule
